[hdl/sbc_pkg.sv]
// sbc_pkg: shared constants and types for the source bracket checker
// no dependencies
`default_nettype none
package sbc_pkg;
    localparam int STACK_DEPTH_DEF = 64;
    localparam int MAX_COLUMNS_DEF = 1024;
    localparam int MAX_LINES_DEF   = 16384;

    localparam logic [1:0] MODE_CHAR  = 2'd0;
    localparam logic [1:0] MODE_BREAK = 2'd1;
    localparam logic [1:0] MODE_FLUSH = 2'd2;

    localparam logic [2:0] ERR_NO_OPENER = 3'd0;
    localparam logic [2:0] ERR_MISMATCH  = 3'd1;
    localparam logic [2:0] ERR_CROSSED   = 3'd2;
    localparam logic [2:0] ERR_UNCLOSED  = 3'd3;
    localparam logic [2:0] ERR_OVERFLOW  = 3'd4;

    // one stack entry: bracket type, line, column
    typedef struct packed {
        logic [1:0]  btype;
        logic [13:0] line;
        logic [9:0]  col;
    } t_entry;

    // one error result
    typedef struct packed {
        logic [2:0]  kind;
        logic [13:0] line;
        logic [9:0]  col;
        logic [7:0]  bchar;
        logic [7:0]  pchar;
        logic [13:0] pline;
        logic        last;
    } t_result;

    function automatic logic [7:0] open_char(input logic [1:0] t);
        case (t)
            2'd1:    open_char = 8'h5B;
            2'd2:    open_char = 8'h7B;
            default: open_char = 8'h28;
        endcase
    endfunction
endpackage
`default_nettype wire

[hdl/sbc_stack.sv]
// sbc_stack: bracket stack memory, one write and one registered read port
// depends on sbc_pkg
`default_nettype none
module sbc_stack #(
    parameter int STACK_DEPTH = sbc_pkg::STACK_DEPTH_DEF,
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
    input  wire logic            i_clk,
    input  wire logic            i_we,
    input  wire logic [AW-1:0]   i_waddr,
    input  wire sbc_pkg::t_entry i_wdata,
    input  wire logic [AW-1:0]   i_raddr,
    output sbc_pkg::t_entry      o_rdata
);
    sbc_pkg::t_entry r_mem [STACK_DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[hdl/source_bracket_checker.sv]
// source_bracket_checker: top level, lexer and stack control
// depends on sbc_pkg and sbc_stack
//
// usage: characters, line breaks (mode 1) and end of text (mode 2) enter on
// the i_valid/o_ready channel; errors leave on o_valid/i_ready, one per
// transaction, last_of_run marking the final error of one input.
// a closer reads the stack memory in turn: request, read data, decide. a
// mismatch gives two errors. end of text pops the stack one entry at a time,
// giving one unclosed error per entry, then returns the block to its reset
// state. results go through a one-entry output register; the block holds
// while it is occupied, so a stalled receiver stalls the scan without loss.
// reset clears the lexer state and stack fill; stack contents stay unknown
// and are only read below the fill level.
`default_nettype none
module source_bracket_checker #(
    parameter int STACK_DEPTH = sbc_pkg::STACK_DEPTH_DEF,
    parameter int MAX_COLUMNS = sbc_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_LINES   = sbc_pkg::MAX_LINES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [1:0] i_mode,
    input  wire logic [7:0] i_character,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [2:0]      o_error_kind,
    output logic [13:0]     o_error_line,
    output logic [9:0]      o_error_column,
    output logic [7:0]      o_bracket_char,
    output logic [7:0]      o_partner_char,
    output logic [13:0]     o_partner_line,
    output logic            o_last_of_run
);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int FW = $clog2(STACK_DEPTH + 1);
    localparam logic [FW-1:0] FULL = FW'(STACK_DEPTH);
    localparam logic [13:0] LINE_MAX = 14'(MAX_LINES - 1);
    localparam logic [9:0]  COL_MAX  = 10'(MAX_COLUMNS - 1);

    typedef enum logic [2:0] {
        SM_NORMAL, SM_LINE_COMMENT, SM_BLOCK_COMMENT, SM_STRING,
        SM_CHAR, SM_INC_ANGLE, SM_INC_QUOTE
    } t_scan;

    typedef enum logic [2:0] {
        ST_RUN, ST_POP_WAIT, ST_POP_DECIDE, ST_CROSS, ST_FLUSH_REQ, ST_FLUSH_WAIT
    } t_state;

    t_state r_state;
    t_scan r_scan;
    logic r_esc, r_slash, r_star;
    logic [3:0] r_inc;
    logic [13:0] r_line;
    logic [9:0] r_col;
    logic [FW-1:0] r_fill;
    logic r_ovalid;
    sbc_pkg::t_result r_out, r_cross;
    logic [7:0] r_closer;
    logic [9:0] r_ccol;

    // memory ports
    logic we;
    logic [AW-1:0] waddr, raddr;
    sbc_pkg::t_entry wdata, rdata;

    sbc_stack #(.STACK_DEPTH(STACK_DEPTH)) u_stack (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    assign o_ready = (r_state == ST_RUN) && !r_ovalid;
    logic acc;
    assign acc = i_valid && o_ready;
    logic obusy;
    assign obusy = r_ovalid && !i_ready;

    // character classification
    logic [7:0] c;
    assign c = i_character;
    logic blank;
    assign blank = c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C || c == 8'h0D;
    logic [7:0] inc_ch;
    always_comb begin
        case (r_inc[2:0])
            3'd0: inc_ch = 8'h23; 3'd1: inc_ch = 8'h69; 3'd2: inc_ch = 8'h6E;
            3'd3: inc_ch = 8'h63; 3'd4: inc_ch = 8'h6C; 3'd5: inc_ch = 8'h75;
            3'd6: inc_ch = 8'h64; default: inc_ch = 8'h65;
        endcase
    end
    logic is_open, is_close;
    logic [1:0] btype;
    always_comb begin
        is_open = 1'b0; is_close = 1'b0; btype = 2'd0;
        case (c)
            8'h28: begin is_open = 1'b1; btype = 2'd0; end
            8'h29: begin is_close = 1'b1; btype = 2'd0; end
            8'h5B: begin is_open = 1'b1; btype = 2'd1; end
            8'h5D: begin is_close = 1'b1; btype = 2'd1; end
            8'h7B: begin is_open = 1'b1; btype = 2'd2; end
            8'h7D: begin is_close = 1'b1; btype = 2'd2; end
            default: ;
        endcase
    end

    // bracket type of a closer
    function automatic logic [1:0] ctype(input logic [7:0] ch);
        case (ch)
            8'h5D:   ctype = 2'd1;
            8'h7D:   ctype = 2'd2;
            default: ctype = 2'd0;
        endcase
    endfunction

    assign raddr = AW'(r_fill - FW'(1));
    assign waddr = AW'(r_fill);
    assign wdata = '{btype: btype, line: r_line, col: r_col};

    // lexer decode for a character transaction
    t_scan n_scan;
    logic n_esc, n_slash, n_star, do_norm;
    always_comb begin
        n_scan = r_scan; n_esc = r_esc; n_slash = r_slash; n_star = r_star;
        do_norm = 1'b0;
        unique case (r_scan)
            SM_LINE_COMMENT: ;
            SM_BLOCK_COMMENT: begin
                if (c == 8'h2F && r_star) n_scan = SM_NORMAL;
                n_star = (c == 8'h2A);
            end
            SM_STRING, SM_CHAR: begin
                if (r_esc) n_esc = 1'b0;
                else if (c == 8'h5C) n_esc = 1'b1;
                else if (c == ((r_scan == SM_STRING) ? 8'h22 : 8'h27)) n_scan = SM_NORMAL;
            end
            SM_INC_ANGLE: if (c == 8'h3E) n_scan = SM_NORMAL;
            SM_INC_QUOTE: if (c == 8'h22) n_scan = SM_NORMAL;
            default: begin
                n_scan = SM_NORMAL;
                do_norm = 1'b1;
                if (r_slash) begin
                    n_slash = 1'b0;
                    if (c == 8'h2F) begin n_scan = SM_LINE_COMMENT; do_norm = 1'b0; end
                    else if (c == 8'h2A) begin
                        n_scan = SM_BLOCK_COMMENT; n_star = 1'b1; do_norm = 1'b0;
                    end
                end
                if (do_norm) begin
                    if (c == 8'h2F) n_slash = 1'b1;
                    else if (c == 8'h22) n_scan = (r_inc == 4'd8) ? SM_INC_QUOTE : SM_STRING;
                    else if (c == 8'h27) n_scan = SM_CHAR;
                    else if (c == 8'h3C && r_inc == 4'd8) n_scan = SM_INC_ANGLE;
                end
            end
        endcase
    end

    logic push_ok;
    assign push_ok = acc && i_mode == sbc_pkg::MODE_CHAR && do_norm && is_open
                     && r_fill < FULL;
    assign we = push_ok;

    // a new result enters the output register
    logic ov_set;
    always_comb begin
        unique case (r_state)
            ST_RUN:        ov_set = acc && i_mode == sbc_pkg::MODE_CHAR && do_norm &&
                                    ((is_open && r_fill >= FULL) ||
                                     (is_close && r_fill == '0));
            ST_POP_DECIDE: ov_set = rdata.btype != ctype(r_closer);
            ST_CROSS:      ov_set = !obusy;
            ST_FLUSH_WAIT: ov_set = 1'b1;
            default:       ov_set = 1'b0;
        endcase
    end

    // output register occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (ov_set) begin
            r_ovalid <= 1'b1;
        end else if (r_ovalid && i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    // control, lexer state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN; r_scan <= SM_NORMAL; r_esc <= 1'b0; r_slash <= 1'b0;
            r_star <= 1'b0; r_inc <= 4'd0; r_line <= '0; r_col <= '0;
            r_fill <= '0;
        end else begin
            unique case (r_state)
                ST_RUN: if (acc) begin
                    if (i_mode == sbc_pkg::MODE_BREAK) begin
                        if (r_scan == SM_LINE_COMMENT || r_scan == SM_INC_ANGLE ||
                            r_scan == SM_INC_QUOTE) r_scan <= SM_NORMAL;
                        r_esc <= 1'b0; r_slash <= 1'b0; r_star <= 1'b0; r_inc <= 4'd0;
                        if (r_line < LINE_MAX) r_line <= r_line + 14'd1;
                        r_col <= '0;
                    end else if (i_mode == sbc_pkg::MODE_FLUSH) begin
                        r_state <= ST_FLUSH_REQ;
                    end else if (i_mode == sbc_pkg::MODE_CHAR) begin
                        if (r_inc < 4'd8 && !(r_inc == 4'd0 && blank))
                            r_inc <= (c == inc_ch) ? r_inc + 4'd1 : 4'd9;
                        r_scan <= n_scan; r_esc <= n_esc; r_slash <= n_slash;
                        r_star <= n_star;
                        if (r_col < COL_MAX) r_col <= r_col + 10'd1;
                        if (do_norm && is_open) begin
                            if (r_fill < FULL) r_fill <= r_fill + FW'(1);
                            else begin
                                r_out <= '{sbc_pkg::ERR_OVERFLOW, r_line, r_col, c,
                                            8'd0, 14'd0, 1'b1};
                            end
                        end else if (do_norm && is_close) begin
                            r_closer <= c; r_ccol <= r_col;
                            if (r_fill == '0) begin
                                r_out <= '{sbc_pkg::ERR_NO_OPENER, r_line, r_col, c,
                                            8'd0, 14'd0, 1'b1};
                            end else r_state <= ST_POP_WAIT;
                        end
                    end
                end
                ST_POP_WAIT: r_state <= ST_POP_DECIDE;
                ST_POP_DECIDE: begin
                    r_fill <= r_fill - FW'(1);
                    if (rdata.btype != ctype(r_closer)) begin
                        r_out <= '{sbc_pkg::ERR_MISMATCH, r_line, r_ccol, r_closer,
                                    sbc_pkg::open_char(rdata.btype), 14'd0, 1'b0};
                        r_cross <= '{sbc_pkg::ERR_CROSSED, rdata.line, rdata.col,
                                     sbc_pkg::open_char(rdata.btype), r_closer,
                                     r_line, 1'b1};
                        r_state <= ST_CROSS;
                    end else r_state <= ST_RUN;
                end
                ST_CROSS: if (!obusy) begin
                    r_out <= r_cross; r_state <= ST_RUN;
                end
                ST_FLUSH_REQ: if (!obusy) begin
                    if (r_fill == '0) begin
                        r_scan <= SM_NORMAL; r_esc <= 1'b0; r_slash <= 1'b0;
                        r_star <= 1'b0; r_inc <= 4'd0; r_line <= '0; r_col <= '0;
                        r_state <= ST_RUN;
                    end else r_state <= ST_FLUSH_WAIT;
                end
                ST_FLUSH_WAIT: begin
                    r_fill <= r_fill - FW'(1);
                    r_out <= '{sbc_pkg::ERR_UNCLOSED, rdata.line, rdata.col,
                                sbc_pkg::open_char(rdata.btype), 8'd0, 14'd0,
                                r_fill == FW'(1)};
                    r_state <= ST_FLUSH_REQ;
                end
                default: r_state <= ST_RUN;
            endcase
        end
    end

    assign o_valid        = r_ovalid;
    assign o_error_kind   = r_out.kind;
    assign o_error_line   = r_out.line;
    assign o_error_column = r_out.col;
    assign o_bracket_char = r_out.bchar;
    assign o_partner_char = r_out.pchar;
    assign o_partner_line = r_out.pline;
    assign o_last_of_run  = r_out.last;

    // checks
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL) else $error("stack fill beyond depth");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> !o_ready) else $error("accept while result pending");
    a_cross_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CROSS) |-> (r_ovalid && r_out.kind == sbc_pkg::ERR_MISMATCH))
        else $error("crossed without mismatch");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POP_WAIT) |-> r_fill != '0) else $error("pop of empty stack");
endmodule
`default_nettype wire

[sim/tb_source_bracket_checker.sv]
// tb_source_bracket_checker: self-checking testbench for the source bracket checker
// holds a scoreboard class with its own lexer and bracket stack predictor
// depends on sbc_pkg and source_bracket_checker
`timescale 1ns / 100ps

// scan states of the predictor lexer
typedef enum logic [2:0] {
    SCAN_NORMAL, SCAN_LINE_CMT, SCAN_BLOCK_CMT, SCAN_STRING,
    SCAN_CHAR_LIT, SCAN_INC_ANGLE, SCAN_INC_QUOTE
} t_scan;

class bracket_scoreboard;
    localparam int DEPTH      = 64;
    localparam int PREFIX_LEN = 8;
    localparam int PREFIX_BAD = 9;

    t_scan           scan;
    bit              escape_on;
    bit              slash_on;
    bit              star_on;
    int              prefix;
    logic [13:0]     line_no;
    logic [9:0]      col_no;
    sbc_pkg::t_entry stk [DEPTH];
    int              fill;
    sbc_pkg::t_result run_q [$];
    sbc_pkg::t_result error_q [$];
    int              fails;

    function void reset_state();
        scan = SCAN_NORMAL;
        escape_on = 0;
        slash_on = 0;
        star_on = 0;
        prefix = 0;
        line_no = '0;
        col_no = '0;
        fill = 0;
    endfunction

    function int pending();
        return error_q.size();
    endfunction

    function logic [7:0] opener_of(input logic [1:0] t);
        case (t)
            2'd1:    return "[";
            2'd2:    return "{";
            default: return "(";
        endcase
    endfunction

    function logic [7:0] include_char(input int idx);
        case (idx)
            0: return "#";
            1: return "i";
            2: return "n";
            3: return "c";
            4: return "l";
            5: return "u";
            6: return "d";
            default: return "e";
        endcase
    endfunction

    function void add_error(input logic [2:0] kind, input logic [13:0] ln,
                            input logic [9:0] cl, input logic [7:0] bc,
                            input logic [7:0] pc, input logic [13:0] pl);
        sbc_pkg::t_result r;
        r.kind = kind;
        r.line = ln;
        r.col = cl;
        r.bchar = bc;
        r.pchar = pc;
        r.pline = pl;
        r.last = 1'b0;
        run_q.push_back(r);
    endfunction

    // plain text: comments, literals and brackets
    function void normal_char(input logic [7:0] ch, input logic [9:0] cl);
        bit inc_line;
        logic [1:0] t;
        sbc_pkg::t_entry e;
        inc_line = (prefix == PREFIX_LEN);
        t = (ch == "(" || ch == ")") ? 2'd0 : (ch == "[" || ch == "]") ? 2'd1 : 2'd2;
        if (ch == "/") begin
            slash_on = 1;
        end else if (ch == "\"") begin
            scan = inc_line ? SCAN_INC_QUOTE : SCAN_STRING;
        end else if (ch == "'") begin
            scan = SCAN_CHAR_LIT;
        end else if (ch == "<" && inc_line) begin
            scan = SCAN_INC_ANGLE;
        end else if (ch == "(" || ch == "[" || ch == "{") begin
            if (fill >= DEPTH) begin
                add_error(sbc_pkg::ERR_OVERFLOW, line_no, cl, ch, 8'h00, 14'h0);
            end else begin
                stk[fill] = '{btype: t, line: line_no, col: cl};
                fill++;
            end
        end else if (ch == ")" || ch == "]" || ch == "}") begin
            if (fill == 0) begin
                add_error(sbc_pkg::ERR_NO_OPENER, line_no, cl, ch, 8'h00, 14'h0);
            end else begin
                fill--;
                e = stk[fill];
                if (e.btype != t) begin
                    add_error(sbc_pkg::ERR_MISMATCH, line_no, cl, ch,
                              opener_of(e.btype), 14'h0);
                    add_error(sbc_pkg::ERR_CROSSED, e.line, e.col,
                              opener_of(e.btype), ch, line_no);
                end
            end
        end
    endfunction

    // one accepted input transaction: predict its errors
    function void note_item(input logic [1:0] mode, input logic [7:0] ch);
        logic [9:0] cl;
        bit done;
        run_q.delete();
        cl = col_no;
        case (mode)
            sbc_pkg::MODE_BREAK: begin
                if (scan == SCAN_LINE_CMT || scan == SCAN_INC_ANGLE ||
                    scan == SCAN_INC_QUOTE)
                    scan = SCAN_NORMAL;
                escape_on = 0;
                slash_on = 0;
                star_on = 0;
                prefix = 0;
                if (line_no != 14'h3FFF) line_no++;
                col_no = '0;
            end
            sbc_pkg::MODE_FLUSH: begin
                while (fill > 0) begin
                    fill--;
                    add_error(sbc_pkg::ERR_UNCLOSED, stk[fill].line, stk[fill].col,
                              opener_of(stk[fill].btype), 8'h00, 14'h0);
                end
                reset_state();
            end
            sbc_pkg::MODE_CHAR: begin
                // include prefix tracking after leading blanks
                if (prefix < PREFIX_LEN) begin
                    if (!(prefix == 0 && (ch == " " || ch == 8'h09 || ch == 8'h0B ||
                                          ch == 8'h0C || ch == 8'h0D))) begin
                        if (ch == include_char(prefix)) prefix++;
                        else prefix = PREFIX_BAD;
                    end
                end
                case (scan)
                    SCAN_LINE_CMT: ;
                    SCAN_BLOCK_CMT: begin
                        if (ch == "/" && star_on) scan = SCAN_NORMAL;
                        star_on = (ch == "*");
                    end
                    SCAN_STRING, SCAN_CHAR_LIT: begin
                        if (escape_on) escape_on = 0;
                        else if (ch == "\\") escape_on = 1;
                        else if (ch == ((scan == SCAN_STRING) ? 8'h22 : 8'h27))
                            scan = SCAN_NORMAL;
                    end
                    SCAN_INC_ANGLE: if (ch == ">") scan = SCAN_NORMAL;
                    SCAN_INC_QUOTE: if (ch == "\"") scan = SCAN_NORMAL;
                    default: begin
                        scan = SCAN_NORMAL;
                        done = 0;
                        // held slash decides on a comment
                        if (slash_on) begin
                            slash_on = 0;
                            if (ch == "/") begin
                                scan = SCAN_LINE_CMT;
                                done = 1;
                            end else if (ch == "*") begin
                                scan = SCAN_BLOCK_CMT;
                                star_on = 1;
                                done = 1;
                            end
                        end
                        if (!done) normal_char(ch, cl);
                    end
                endcase
                if (col_no != 10'h3FF) col_no++;
            end
            default: ;
        endcase
        if (run_q.size() > 0) begin
            run_q[run_q.size() - 1].last = 1'b1;
            foreach (run_q[i]) error_q.push_back(run_q[i]);
        end
    endfunction

    // one accepted result transaction against the oldest expectation
    function void check_result(input sbc_pkg::t_result got);
        sbc_pkg::t_result exp_r;
        if (error_q.size() == 0) begin
            $error("unexpected result kind %0d line %0d col %0d",
                   got.kind, got.line, got.col);
            fails++;
            return;
        end
        exp_r = error_q.pop_front();
        if (got.kind != exp_r.kind) begin
            $error("error_kind expected %0d actual %0d", exp_r.kind, got.kind);
            fails++;
        end
        if (got.line != exp_r.line) begin
            $error("error_line expected %0d actual %0d", exp_r.line, got.line);
            fails++;
        end
        if (got.col != exp_r.col) begin
            $error("error_column expected %0d actual %0d", exp_r.col, got.col);
            fails++;
        end
        if (got.bchar != exp_r.bchar) begin
            $error("bracket_char expected %h actual %h", exp_r.bchar, got.bchar);
            fails++;
        end
        if (got.pchar != exp_r.pchar) begin
            $error("partner_char expected %h actual %h", exp_r.pchar, got.pchar);
            fails++;
        end
        if (got.pline != exp_r.pline) begin
            $error("partner_line expected %0d actual %0d", exp_r.pline, got.pline);
            fails++;
        end
        if (got.last != exp_r.last) begin
            $error("last_of_run expected %0d actual %0d", exp_r.last, got.last);
            fails++;
        end
    endfunction
endclass

module tb_source_bracket_checker;
    localparam int RANDOM_ITEMS = 330;
    localparam int IDLE_LIMIT   = 5000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 200;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_mode;
    logic [7:0]  i_character;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_error_kind;
    logic [13:0] o_error_line;
    logic [9:0]  o_error_column;
    logic [7:0]  o_bracket_char;
    logic [7:0]  o_partner_char;
    logic [13:0] o_partner_line;
    logic        o_last_of_run;

    bracket_scoreboard sb;
    int          sender_idle;
    int          recv_stall;
    bit          hold_req;
    int          hold_left;
    int          idle_count;
    int          sent_count;
    logic [7:0]  open_q [$];

    source_bracket_checker DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_mode(i_mode), .i_character(i_character),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_error_kind(o_error_kind), .o_error_line(o_error_line),
        .o_error_column(o_error_column), .o_bracket_char(o_bracket_char),
        .o_partner_char(o_partner_char), .o_partner_line(o_partner_line),
        .o_last_of_run(o_last_of_run)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // monitor both channels at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.note_item(i_mode, i_character);
            if (o_valid && i_ready)
                sb.check_result('{kind: o_error_kind, line: o_error_line,
                                  col: o_error_column, bchar: o_bracket_char,
                                  pchar: o_partner_char, pline: o_partner_line,
                                  last: o_last_of_run});
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_count <= 0;
            else idle_count <= idle_count + 1;
            if (idle_count >= IDLE_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // receiver: random stalls plus a long hold-off on request
    initial begin
        i_ready = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready = 1'b0;
            end else begin
                i_ready = ($urandom_range(99) >= recv_stall);
            end
        end
    end

    // one input transaction, called and returning at a falling edge
    task automatic send_item(input logic [1:0] mode, input logic [7:0] ch);
        while ($urandom_range(99) < sender_idle) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_mode = mode;
        i_character = ch;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (mode != 2'd3) sent_count++;
        @(negedge i_clk);
    endtask

    task automatic send_char(input logic [7:0] ch);
        send_item(sbc_pkg::MODE_CHAR, ch);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    task automatic send_break();
        send_item(sbc_pkg::MODE_BREAK, 8'($urandom_range(255)));
    endtask

    task automatic send_flush();
        send_item(sbc_pkg::MODE_FLUSH, 8'($urandom_range(255)));
        open_q.delete();
    endtask

    task automatic wait_drained();
        i_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    // literal body drawn from a pool that includes brackets and escapes
    task automatic send_literal_body(input logic [7:0] quote);
        string pool;
        int n;
        logic [7:0] c;
        pool = "ab([{}])*/ \\";
        n = $urandom_range(6);
        for (int i = 0; i < n; i++) begin
            c = pool[$urandom_range(pool.len() - 1)];
            send_char(c);
            if (c == "\\") send_char($urandom_range(1) ? quote : "n");
        end
        send_char(quote);
    endtask

    // one random token of C-like text
    task automatic send_token();
        int r;
        logic [7:0] c;
        string pool;
        r = $urandom_range(99);
        pool = "()[]{}x*/\"'<> ";
        if (r < 14) begin
            c = ($urandom_range(2) == 0) ? "(" : ($urandom_range(1) ? "[" : "{");
            open_q.push_back(c);
            send_char(c);
        end else if (r < 28) begin
            if (open_q.size() > 0 && $urandom_range(99) < 85) begin
                c = open_q.pop_back();
                send_char(c == "(" ? ")" : (c == "[" ? "]" : "}"));
            end else begin
                if (open_q.size() > 0) void'(open_q.pop_back());
                c = ($urandom_range(2) == 0) ? ")" : ($urandom_range(1) ? "]" : "}");
                send_char(c);
            end
        end else if (r < 40) begin
            repeat ($urandom_range(1, 6)) send_char(8'($urandom_range("a", "z")));
        end else if (r < 48) begin
            send_char("\"");
            send_literal_body("\"");
        end else if (r < 53) begin
            send_char("'");
            send_literal_body("'");
        end else if (r < 59) begin
            send_text("//");
            repeat ($urandom_range(5)) send_char(pool[$urandom_range(pool.len() - 1)]);
            send_break();
        end else if (r < 65) begin
            send_text("/*");
            repeat ($urandom_range(6)) begin
                if ($urandom_range(9) == 0) send_break();
                else send_char(pool[$urandom_range(pool.len() - 1)]);
            end
            send_text("*/");
        end else if (r < 70) begin
            repeat ($urandom_range(2)) send_char($urandom_range(1) ? " " : 8'h09);
            send_text("#include");
            send_char(" ");
            if ($urandom_range(1)) begin
                send_char("<");
                send_text("a(b].h");
                if ($urandom_range(3) != 0) send_char(">");
            end else begin
                send_char("\"");
                send_text("c{d).h");
                if ($urandom_range(3) != 0) send_char("\"");
            end
            send_break();
        end else if (r < 80) begin
            send_break();
        end else if (r < 86) begin
            c = ($urandom_range(3) == 0) ? 8'h0B : ($urandom_range(1) ? 8'h0C : 8'h0D);
            send_char(c);
        end else if (r < 92) begin
            send_char(8'($urandom_range(255)));
        end else if (r < 95) begin
            send_item(2'd3, 8'($urandom_range(255)));
        end else if (r < 97) begin
            send_text("a/b");
        end else begin
            send_flush();
        end
    endtask

    initial begin
        int base;
        int phase;
        bit held;
        bit paused;
        sb = new;
        sb.reset_state();
        sb.fails = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_mode = sbc_pkg::MODE_CHAR;
        i_character = 8'h00;
        sender_idle = 0;
        recv_stall = 0;
        hold_req = 0;
        idle_count = 0;
        sent_count = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: balanced, stray closer, mismatch, comments, literals, include
        send_text("([{}])");
        send_text(")(]");
        send_text("/*/(*/");
        send_text("'\\'('\"(\"");
        send_break();
        send_char(8'h09);
        send_text("#include <(>");
        send_break();
        send_char("/");
        send_break();
        send_char("{");
        send_char(8'hFF);
        send_char(8'h00);
        send_item(2'd3, 8'hA5);
        send_flush();

        // deep nesting past the stack depth
        repeat (66) send_char("{");
        send_flush();

        // random text across idling phases
        base = sent_count;
        held = 0;
        paused = 0;
        while (sent_count - base < RANDOM_ITEMS) begin
            phase = ((sent_count - base) / 40) % 4;
            sender_idle = (phase == 1) ? 49 : (phase == 3) ? 9 : 0;
            recv_stall  = (phase == 2) ? 49 : (phase == 3) ? 9 : 0;
            if (!held && sent_count - base > 150) begin
                held = 1;
                hold_req = 1;
                repeat (8) send_text("(]");
            end
            if (!paused && sent_count - base > 300) begin
                paused = 1;
                wait_drained();
            end
            send_token();
        end
        send_flush();

        // drain
        i_valid = 1'b0;
        recv_stall = 0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.fails == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
